### sv/alpn_pkg.sv
// ---------------------------------------------------------------------------
// ALPN selector package
// Shared codes, types and name-matching functions for the ALPN selector.
// ---------------------------------------------------------------------------
package alpn_pkg;

	// Default ceiling on the number of parsed list bytes.
	localparam int LIST_BYTES_MAX_DEF = 65535;

	// Field widths fixed by the interface.
	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 16;
	localparam int CHOICE_W = 2;
	localparam int LENGTH_W = 4;

	// Selection codes.
	localparam logic [CHOICE_W-1:0] CHOICE_H2   = 2'd0;
	localparam logic [CHOICE_W-1:0] CHOICE_HTTP = 2'd1;
	localparam logic [CHOICE_W-1:0] CHOICE_NONE = 2'd2;

	// Name lengths reported with a selection.
	localparam logic [LENGTH_W-1:0] LEN_H2   = 4'd2;
	localparam logic [LENGTH_W-1:0] LEN_HTTP = 4'd8;
	localparam logic [LENGTH_W-1:0] LEN_NONE = 4'd0;

	// Parser phase codes; the unused code behaves as stopped.
	localparam logic [1:0] PHASE_LEN  = 2'd0;
	localparam logic [1:0] PHASE_BODY = 2'd1;
	localparam logic [1:0] PHASE_STOP = 2'd2;

	// One list word as handed to the parser.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
	} step_t;

	// One selection result.
	typedef struct packed {
		logic [CHOICE_W-1:0] choice;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
	} result_t;

	// Characters of "h2" by position.
	function automatic logic [BYTE_W-1:0] short_char(input logic idx);
		logic [BYTE_W-1:0] c;
		c = idx ? 8'h32 : 8'h68;
		return c;
	endfunction

	// Characters of "http/1.1" by position.
	function automatic logic [BYTE_W-1:0] long_char(input logic [2:0] idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			3'd0: c = 8'h68;
			3'd1: c = 8'h74;
			3'd2: c = 8'h74;
			3'd3: c = 8'h70;
			3'd4: c = 8'h2f;
			3'd5: c = 8'h31;
			3'd6: c = 8'h2e;
			3'd7: c = 8'h31;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### sv/alpn_parse_core.sv
// ---------------------------------------------------------------------------
// ALPN list parser core
// Walks the list one word per step, tracks entry matches and forms the
// selection on the last word, then returns to its reset state.
// ---------------------------------------------------------------------------
module alpn_parse_core #(
	parameter int LIST_BYTES_MAX = alpn_pkg::LIST_BYTES_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  alpn_pkg::step_t  step,
	output alpn_pkg::result_t result
);
	import alpn_pkg::*;

	localparam logic [OFFSET_W-1:0] POS_MAX = OFFSET_W'(LIST_BYTES_MAX);

	logic [1:0]          phase_q;
	logic [BYTE_W-1:0]   left_q;
	logic [BYTE_W-1:0]   elen_q;
	logic [OFFSET_W-1:0] estart_q;
	logic [OFFSET_W-1:0] pos_q;
	logic                m_short_q, m_long_q;
	logic                f_short_q, f_long_q;
	logic [OFFSET_W-1:0] o_short_q, o_long_q;

	logic [1:0]          phase_d;
	logic [BYTE_W-1:0]   left_d;
	logic [BYTE_W-1:0]   elen_d;
	logic [OFFSET_W-1:0] estart_d;
	logic [OFFSET_W-1:0] pos_d;
	logic                m_short_d, m_long_d;
	logic                f_short_d, f_long_d;
	logic [OFFSET_W-1:0] o_short_d, o_long_d;

	// Next state for one list word.
	always_comb begin
		logic [BYTE_W-1:0] idx;
		logic [BYTE_W-1:0] left_m1;
		logic              ms, ml;
		phase_d   = phase_q;
		left_d    = left_q;
		elen_d    = elen_q;
		estart_d  = estart_q;
		pos_d     = pos_q;
		m_short_d = m_short_q;
		m_long_d  = m_long_q;
		f_short_d = f_short_q;
		f_long_d  = f_long_q;
		o_short_d = o_short_q;
		o_long_d  = o_long_q;
		idx       = elen_q - left_q;
		left_m1   = left_q - 8'd1;
		ms        = m_short_q && (idx < 8'd2) && (short_char(idx[0]) == step.data);
		ml        = m_long_q && (idx < 8'd8) && (long_char(idx[2:0]) == step.data);
		if (pos_q < POS_MAX) begin
			pos_d = pos_q + 16'd1;
			case (phase_q)
				PHASE_LEN: begin
					if (step.data == 8'd0) begin
						phase_d = PHASE_STOP;
					end else begin
						elen_d    = step.data;
						left_d    = step.data;
						estart_d  = pos_q + 16'd1;
						m_short_d = (step.data == 8'd2);
						m_long_d  = (step.data == 8'd8);
						phase_d   = PHASE_BODY;
					end
				end
				PHASE_BODY: begin
					m_short_d = ms;
					m_long_d  = ml;
					left_d    = left_m1;
					if (left_m1 == 8'd0) begin
						if (ms && !f_short_q) begin
							f_short_d = 1'b1;
							o_short_d = estart_q;
						end
						if (ml && !f_long_q) begin
							f_long_d = 1'b1;
							o_long_d = estart_q;
						end
						phase_d = PHASE_LEN;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Selection from the updated found flags.
	always_comb begin
		if (f_short_d) begin
			result.choice = CHOICE_H2;
			result.offset = o_short_d;
			result.length = LEN_H2;
		end else if (f_long_d) begin
			result.choice = CHOICE_HTTP;
			result.offset = o_long_d;
			result.length = LEN_HTTP;
		end else begin
			result.choice = CHOICE_NONE;
			result.offset = '0;
			result.length = LEN_NONE;
		end
	end

	// Parser state; the last word returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_LEN;
			left_q    <= '0;
			elen_q    <= '0;
			estart_q  <= '0;
			pos_q     <= '0;
			m_short_q <= 1'b0;
			m_long_q  <= 1'b0;
			f_short_q <= 1'b0;
			f_long_q  <= 1'b0;
			o_short_q <= '0;
			o_long_q  <= '0;
		end else if (step.valid) begin
			if (step.last) begin
				phase_q   <= PHASE_LEN;
				left_q    <= '0;
				elen_q    <= '0;
				estart_q  <= '0;
				pos_q     <= '0;
				m_short_q <= 1'b0;
				m_long_q  <= 1'b0;
				f_short_q <= 1'b0;
				f_long_q  <= 1'b0;
				o_short_q <= '0;
				o_long_q  <= '0;
			end else begin
				phase_q   <= phase_d;
				left_q    <= left_d;
				elen_q    <= elen_d;
				estart_q  <= estart_d;
				pos_q     <= pos_d;
				m_short_q <= m_short_d;
				m_long_q  <= m_long_d;
				f_short_q <= f_short_d;
				f_long_q  <= f_long_d;
				o_short_q <= o_short_d;
				o_long_q  <= o_long_d;
			end
		end
	end

endmodule

### sv/alpn_protocol_selector.sv
// ---------------------------------------------------------------------------
// ALPN protocol selector
// Picks h2, else http/1.1, from a TLS ALPN protocol list streamed by word.
// ---------------------------------------------------------------------------
// The list enters one byte word per cycle on the list channel, with
// last_byte marking its final word; one selection leaves on the result
// channel per list, from the result register that is loaded as the last
// word leaves the input register. Each word is registered at the input and
// folded into the parser state as it moves on, so a new word is taken every
// cycle; the only stall is a last word waiting while an earlier result is
// still held in the output register. Offsets count from the first list word;
// words beyond LIST_BYTES_MAX are not parsed but their last mark is honored.
module alpn_protocol_selector #(
	parameter int LIST_BYTES_MAX = alpn_pkg::LIST_BYTES_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            list_valid,
	output logic                            list_ready,
	input  logic [alpn_pkg::BYTE_W-1:0]     list_byte,
	input  logic                            last_byte,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [alpn_pkg::CHOICE_W-1:0]   choice,
	output logic [alpn_pkg::OFFSET_W-1:0]   name_offset,
	output logic [alpn_pkg::LENGTH_W-1:0]   name_length
);
	import alpn_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              advance;
	step_t             step;
	result_t           sel;

	// A word moves on unless it is a last word and the result slot is full and not being taken.
	assign advance    = valid_s1 && (!last_s1 || !result_valid || result_ready);
	assign list_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (list_ready) begin
			valid_s1 <= list_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (list_ready) begin
			byte_s1 <= list_byte;
			last_s1 <= last_byte;
		end
	end

	assign step.valid = advance;
	assign step.data  = byte_s1;
	assign step.last  = last_s1;

	alpn_parse_core #(
		.LIST_BYTES_MAX(LIST_BYTES_MAX)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.result (sel)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			choice      <= sel.choice;
			name_offset <= sel.offset;
			name_length <= sel.length;
		end
	end

endmodule

### sv/alpn_sel_checker.sv
// ---------------------------------------------------------------------------
// ALPN selector port checker
// Watches the selector's ports for result handshake and encoding rules.
// ---------------------------------------------------------------------------
module alpn_sel_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [alpn_pkg::CHOICE_W-1:0] choice,
	input logic [alpn_pkg::OFFSET_W-1:0] name_offset,
	input logic [alpn_pkg::LENGTH_W-1:0] name_length
);
	import alpn_pkg::*;

	// A stalled result holds its word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(choice)
		&& $stable(name_offset) && $stable(name_length))
		else $error("result word changed while stalled");

	// An h2 selection reports a two-byte name at a nonzero offset.
	a_h2_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && choice == CHOICE_H2 |-> name_length == LEN_H2
		&& name_offset != 16'd0)
		else $error("h2 selection with wrong length or offset");

	// An http/1.1 selection reports an eight-byte name at a nonzero offset.
	a_http_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && choice == CHOICE_HTTP |-> name_length == LEN_HTTP
		&& name_offset != 16'd0)
		else $error("http/1.1 selection with wrong length or offset");

	// No selection carries zero offset and length, and no other code occurs.
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && choice != CHOICE_H2 && choice != CHOICE_HTTP
		|-> choice == CHOICE_NONE && name_offset == 16'd0 && name_length == LEN_NONE)
		else $error("bad no-selection word");

endmodule

bind alpn_protocol_selector alpn_sel_checker u_alpn_sel_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.choice       (choice),
	.name_offset  (name_offset),
	.name_length  (name_length)
);

### bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ALPN protocol selector testbench
// Streams ALPN protocol lists into the selector word by word, keeps its own
// model of the parser, and checks every selection that leaves the block.
// ---------------------------------------------------------------------------
// Directed lists cover the zero length stop, truncated entries and a stop
// that hides a later h2. They are followed by random lists that are
// mostly well formed, with near misses, noise, truncation and lists that
// run past the parse ceiling. The sender idles in bursts and the receiver
// stalls on its own pattern, with periodic long hold-offs that back the
// block up into its input.
module tb_top;
	import alpn_pkg::*;

	// A small parse ceiling makes over-long lists cheap to reach.
	localparam int LIST_MAX    = 64;
	localparam int RANDOM_WORDS = 1250;
	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 20;

	// Reference names, first character in the top byte.
	localparam logic [15:0] H2_NAME   = "h2";
	localparam logic [63:0] HTTP_NAME = "http/1.1";

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} list_word_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                list_valid   = 1'b0;
	logic                list_ready;
	logic [BYTE_W-1:0]   list_byte    = '0;
	logic                last_byte    = 1'b0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [CHOICE_W-1:0] choice;
	logic [OFFSET_W-1:0] name_offset;
	logic [LENGTH_W-1:0] name_length;

	// Pending list words and the selections they are expected to produce.
	list_word_t  word_q[$];
	result_t     selection_q[$];
	logic [7:0]  list_buf[$];
	int          words_total    = 0;
	int          words_accepted = 0;
	int          random_words   = 0;
	int          mismatch_count = 0;
	int          cycle_count    = 0;

	// Parser model state.
	logic [1:0]          ph;
	logic [7:0]          entry_left;
	logic [7:0]          entry_len;
	logic [OFFSET_W-1:0] entry_first;
	logic [OFFSET_W-1:0] list_pos;
	logic                maybe_h2;
	logic                maybe_http;
	logic                seen_h2;
	logic [OFFSET_W-1:0] h2_at;
	logic                seen_http;
	logic [OFFSET_W-1:0] http_at;

	alpn_protocol_selector #(
		.LIST_BYTES_MAX(LIST_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.list_valid   (list_valid),
		.list_ready   (list_ready),
		.list_byte    (list_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.choice       (choice),
		.name_offset  (name_offset),
		.name_length  (name_length)
	);

	always #5 clk = ~clk;

	// Return the parser model to its state at the start of a list.
	task automatic clear_parser();
		ph          = PHASE_LEN;
		entry_left  = '0;
		entry_len   = '0;
		entry_first = '0;
		list_pos    = '0;
		maybe_h2    = 1'b0;
		maybe_http  = 1'b0;
		seen_h2     = 1'b0;
		h2_at       = '0;
		seen_http   = 1'b0;
		http_at     = '0;
	endtask

	// Fold one accepted word into the model; the last word yields a selection.
	task automatic predict_selection(input logic [7:0] b, input logic last);
		logic [7:0] idx;
		result_t    sel;
		if (list_pos < LIST_MAX) begin
			case (ph)
				PHASE_LEN: begin
					if (b == 8'd0) begin
						ph = PHASE_STOP;
					end else begin
						entry_len   = b;
						entry_left  = b;
						entry_first = list_pos + 1'b1;
						maybe_h2    = (b == 8'd2);
						maybe_http  = (b == 8'd8);
						ph          = PHASE_BODY;
					end
				end
				PHASE_BODY: begin
					idx = entry_len - entry_left;
					if (idx >= 8'd2)
						maybe_h2 = 1'b0;
					else if (H2_NAME[8*(1-idx) +: 8] != b)
						maybe_h2 = 1'b0;
					if (idx >= 8'd8)
						maybe_http = 1'b0;
					else if (HTTP_NAME[8*(7-idx) +: 8] != b)
						maybe_http = 1'b0;
					entry_left = entry_left - 1'b1;
					if (entry_left == 8'd0) begin
						if (maybe_h2 && !seen_h2) begin
							seen_h2 = 1'b1;
							h2_at   = entry_first;
						end
						if (maybe_http && !seen_http) begin
							seen_http = 1'b1;
							http_at   = entry_first;
						end
						ph = PHASE_LEN;
					end
				end
				default: ;
			endcase
			list_pos = list_pos + 1'b1;
		end
		if (last) begin
			if (seen_h2) begin
				sel.choice = CHOICE_H2;
				sel.offset = h2_at;
				sel.length = LEN_H2;
			end else if (seen_http) begin
				sel.choice = CHOICE_HTTP;
				sel.offset = http_at;
				sel.length = LEN_HTTP;
			end else begin
				sel.choice = CHOICE_NONE;
				sel.offset = '0;
				sel.length = LEN_NONE;
			end
			selection_q.push_back(sel);
			clear_parser();
		end
	endtask

	// Move the list being built into the pending queue, marking its last word.
	task automatic commit_list();
		list_word_t w;
		int         i;
		for (i = 0; i < list_buf.size(); i++) begin
			w.data = list_buf[i];
			w.last = (i == list_buf.size() - 1);
			word_q.push_back(w);
		end
		words_total += list_buf.size();
		list_buf.delete();
	endtask

	task automatic add_h2();
		list_buf.push_back(8'd2);
		list_buf.push_back(H2_NAME[15:8]);
		list_buf.push_back(H2_NAME[7:0]);
	endtask

	task automatic add_http();
		int k;
		list_buf.push_back(8'd8);
		for (k = 0; k < 8; k++)
			list_buf.push_back(HTTP_NAME[8*(7-k) +: 8]);
	endtask

	// An entry of the given length with bytes drawn partly from the http/1.1 name.
	task automatic add_random_entry(input int len);
		int k;
		list_buf.push_back(len[7:0]);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 2) == 0)
				list_buf.push_back(HTTP_NAME[8*$urandom_range(0, 7) +: 8]);
			else
				list_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// A name that differs from h2 or http/1.1 in one byte or in its length.
	task automatic add_near_miss();
		int         k;
		int         bad;
		logic [7:0] c;
		logic       use_h2;
		use_h2 = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 2))
			0: begin
				bad = use_h2 ? $urandom_range(0, 1) : $urandom_range(0, 7);
				list_buf.push_back(use_h2 ? 8'd2 : 8'd8);
				for (k = 0; k < (use_h2 ? 2 : 8); k++) begin
					c = use_h2 ? H2_NAME[8*(1-k) +: 8] : HTTP_NAME[8*(7-k) +: 8];
					if (k == bad)
						c = c ^ (8'd1 << $urandom_range(0, 7));
					list_buf.push_back(c);
				end
			end
			1: begin
				// One byte too long.
				list_buf.push_back(use_h2 ? 8'd3 : 8'd9);
				for (k = 0; k < (use_h2 ? 2 : 8); k++)
					list_buf.push_back(use_h2 ? H2_NAME[8*(1-k) +: 8]
						: HTTP_NAME[8*(7-k) +: 8]);
				list_buf.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				// One byte short: a prefix of the name.
				list_buf.push_back(use_h2 ? 8'd1 : 8'd7);
				for (k = 0; k < (use_h2 ? 1 : 7); k++)
					list_buf.push_back(use_h2 ? H2_NAME[8*(1-k) +: 8]
						: HTTP_NAME[8*(7-k) +: 8]);
			end
		endcase
	endtask

	// One random list, mostly well formed, sometimes broken or over-long.
	task automatic build_random_list();
		int n;
		int k;
		int r;
		int cut;
		n = $urandom_range(1, 6);
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 22) begin
				add_h2();
			end else if (r < 44) begin
				add_http();
			end else if (r < 64) begin
				add_near_miss();
			end else if (r < 88) begin
				add_random_entry($urandom_range(1, 12));
			end else if (r < 94) begin
				// Zero length byte stops the parse for the rest of the list.
				list_buf.push_back(8'd0);
				break;
			end else begin
				// Long entry that the list never finishes.
				list_buf.push_back(8'($urandom_range(13, 255)));
				repeat ($urandom_range(0, 6))
					list_buf.push_back(8'($urandom_range(0, 255)));
				break;
			end
		end
		if ($urandom_range(0, 99) < 15 && list_buf.size() > 1) begin
			cut = $urandom_range(1, list_buf.size() - 1);
			repeat (cut)
				void'(list_buf.pop_back());
		end
		if ($urandom_range(0, 99) < 10)
			repeat ($urandom_range(1, 4))
				list_buf.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 99) < 6) begin
			while (list_buf.size() <= LIST_MAX + 8) begin
				case ($urandom_range(0, 2))
					0: add_h2();
					1: add_http();
					default: add_random_entry($urandom_range(1, 12));
				endcase
			end
		end
		if (list_buf.size() == 0)
			add_h2();
		random_words += (list_buf.size() < LIST_MAX) ? list_buf.size() : LIST_MAX;
		commit_list();
	endtask

	// Sender: words go out in bursts separated by random gaps.
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		list_word_t w;
		if (!arst_n) begin
			list_valid <= 1'b0;
			list_byte  <= '0;
			last_byte  <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (list_valid && list_ready) begin
				predict_selection(list_byte, last_byte);
				words_accepted++;
			end
			if (!(list_valid && !list_ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					list_valid <= 1'b0;
				end else if (word_q.size() > 0) begin
					w = word_q.pop_front();
					list_valid <= 1'b1;
					list_byte  <= w.data;
					last_byte  <= w.last;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
							: $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0
							: $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 3);
					end else begin
						burst_left--;
					end
				end else begin
					list_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, clear stretches, and a periodic long hold-off.
	int rx_cycle = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_cycle = 0;
		end else begin
			rx_cycle++;
			if ((rx_cycle % 1500) >= 600 && (rx_cycle % 1500) < 900)
				result_ready <= 1'b0;
			else if (rx_cycle[9])
				result_ready <= 1'b1;
			else
				result_ready <= ($urandom_range(0, 9) < 6);
		end
	end

	// Result check against the oldest expected selection.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (selection_q.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected selection: choice %0d offset %0d length %0d",
						choice, name_offset, name_length);
				mismatch_count++;
			end else begin
				want = selection_q.pop_front();
				if (choice !== want.choice || name_offset !== want.offset
						|| name_length !== want.length) begin
					if (mismatch_count < 10)
						$display("selection mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
							want.choice, want.offset, want.length,
							choice, name_offset, name_length);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		clear_parser();

		// Single zero length byte, then a single unfinished length byte.
		list_buf.push_back(8'h00);
		commit_list();
		list_buf.push_back(8'hff);
		commit_list();
		// A lone h2, and h2 after a one byte entry.
		add_h2();
		commit_list();
		list_buf.push_back(8'd1);
		list_buf.push_back(H2_NAME[15:8]);
		add_h2();
		commit_list();
		// http/1.1 then a stop that hides a later h2.
		add_http();
		list_buf.push_back(8'd0);
		add_h2();
		commit_list();
		// h2 with its length one too large runs off the end.
		list_buf.push_back(8'd3);
		list_buf.push_back(H2_NAME[15:8]);
		list_buf.push_back(H2_NAME[7:0]);
		commit_list();

		while (random_words < RANDOM_WORDS)
			build_random_list();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (words_accepted < words_total)
			@(negedge clk);
		while (selection_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
